@@ sv/mfmc_pkg.sv @@
// Shared constants, state encoding and index helper for the max-flow engine.
`timescale 1ns / 1ps
package mfmc_pkg;

    localparam int unsigned MAX_VERTS_DEF  = 64;
    localparam int unsigned MAX_EDGES_DEF  = 32;
    localparam int unsigned PUSH_LIMIT_DEF = 1000000000;
    localparam int unsigned CAP_W          = 30;
    localparam int unsigned VNUM_W         = 7;
    localparam int unsigned FLOW_W         = 35;
    localparam int unsigned CNT_W          = 6;
    localparam logic [VNUM_W-1:0] VCOUNT_RST = 7'd2;

    typedef enum logic [4:0] {
        S_LOAD,
        S_BFS_INIT,
        S_BFS_POP,
        S_BFS_DEQ,
        S_BFS_LVL,
        S_BFS_ARC,
        S_BFS_EV,
        S_BFS_END,
        S_AUG_INIT,
        S_AUG_TOP,
        S_SCAN_EV,
        S_SCAN_CHK,
        S_ENTER,
        S_POP,
        S_APPLY_RS,
        S_APPLY_RF,
        S_APPLY_WR,
        S_APPLY_END,
        S_CNT_RD,
        S_CNT_EV,
        S_HDR,
        S_EM_RD,
        S_EM_EV
    } t_state;

    // (v - 1) mod m by shifted compare-subtract steps
    function automatic int unsigned vert_index(logic [VNUM_W-1:0] v, int unsigned m);
        int unsigned x;
        x = int'(v) + m - 1;
        for (int s = 6; s >= 0; s--) begin
            if (x >= (m << s)) begin
                x = x - (m << s);
            end
        end
        return x;
    endfunction

endpackage

@@ sv/mfmc_arc_table.sv @@
// Edge table with per-edge flow; presents one arc view per read and updates flow.
`timescale 1ns / 1ps
module mfmc_arc_table
    import mfmc_pkg::*;
#(
    parameter int unsigned MAX_VERTS = MAX_VERTS_DEF,
    parameter int unsigned MAX_EDGES = MAX_EDGES_DEF,
    localparam int unsigned VW  = $clog2(MAX_VERTS),
    localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    localparam int unsigned PW  = $clog2(2 * MAX_EDGES + 1),
    localparam int unsigned XW  = VW + 8
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [EAW-1:0]      i_waddr,
    input  logic [VW-1:0]       i_wfrom,
    input  logic [VW-1:0]       i_wto,
    input  logic [CAP_W-1:0]    i_wcap,
    input  logic                i_re,
    input  logic [PW-1:0]       i_raddr,
    input  logic                i_upd,
    input  logic [CAP_W-1:0]    i_amt,
    input  logic [XW-1:0]       i_n,
    output logic [VW-1:0]       o_from,
    output logic [VW-1:0]       o_to,
    output logic signed [31:0]  o_res,
    output logic                o_live
);

    localparam int unsigned EW = 2 * VW + CAP_W;

    logic [EW-1:0]        edge_mem [MAX_EDGES];
    logic signed [30:0]   flow_mem [MAX_EDGES];
    logic [EW-1:0]        r_e;
    logic signed [30:0]   r_g;
    logic                 r_d;
    logic [EAW-1:0]       r_ea;
    logic [VW-1:0]        e_f;
    logic [VW-1:0]        e_t;
    logic signed [31:0]   cap_s;
    logic signed [31:0]   g_s;
    logic signed [30:0]   amt_s;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            edge_mem[i_waddr] <= {i_wcap, i_wto, i_wfrom};
            flow_mem[i_waddr] <= '0;
        end else if (i_upd) begin
            flow_mem[r_ea] <= r_d ? (r_g - amt_s) : (r_g + amt_s);
        end
        if (i_re) begin
            r_e  <= edge_mem[i_raddr[EAW:1]];
            r_g  <= flow_mem[i_raddr[EAW:1]];
            r_d  <= i_raddr[0];
            r_ea <= i_raddr[EAW:1];
        end
    end

    always_comb begin
        amt_s  = $signed({1'b0, i_amt});
        e_f    = r_e[VW-1:0];
        e_t    = r_e[2*VW-1:VW];
        cap_s  = $signed({2'b00, r_e[EW-1:2*VW]});
        g_s    = 32'(r_g);
        o_from = r_d ? e_t : e_f;
        o_to   = r_d ? e_f : e_t;
        o_res  = r_d ? (cap_s + g_s) : (cap_s - g_s);
        o_live = (XW'(e_f) < i_n) && (XW'(e_t) < i_n);
    end

endmodule

@@ sv/mfmc_vertex_store.sv @@
// Per-vertex level and arc pointer memories with reach and pointer valid bits.
`timescale 1ns / 1ps
module mfmc_vertex_store
    import mfmc_pkg::*;
#(
    parameter int unsigned MAX_VERTS = MAX_VERTS_DEF,
    parameter int unsigned MAX_EDGES = MAX_EDGES_DEF,
    localparam int unsigned VW = $clog2(MAX_VERTS),
    localparam int unsigned PW = $clog2(2 * MAX_EDGES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_lvl_clr,
    input  logic                 i_lvl_we,
    input  logic [VW-1:0]        i_lvl_waddr,
    input  logic [VW-1:0]        i_lvl_wdata,
    input  logic                 i_lvl_re,
    input  logic [VW-1:0]        i_lvl_raddr,
    output logic [VW-1:0]        o_lvl_rdata,
    output logic [MAX_VERTS-1:0] o_reach,
    input  logic                 i_ptr_clr,
    input  logic                 i_ptr_we,
    input  logic [VW-1:0]        i_ptr_waddr,
    input  logic [PW-1:0]        i_ptr_wdata,
    input  logic                 i_ptr_re,
    input  logic [VW-1:0]        i_ptr_raddr,
    output logic [PW-1:0]        o_ptr_rdata
);

    logic [VW-1:0]        lvl_mem [MAX_VERTS];
    logic [PW-1:0]        ptr_mem [MAX_VERTS];
    logic [MAX_VERTS-1:0] r_reach, n_reach;
    logic [MAX_VERTS-1:0] r_pvalid, n_pvalid;
    logic [PW-1:0]        r_ptr_rd;
    logic                 r_ptr_rv;

    always_comb begin
        n_reach = i_lvl_clr ? '0 : r_reach;
        if (i_lvl_we) begin
            n_reach[i_lvl_waddr] = 1'b1;
        end
        n_pvalid = i_ptr_clr ? '0 : r_pvalid;
        if (i_ptr_we) begin
            n_pvalid[i_ptr_waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reach  <= '0;
            r_pvalid <= '0;
            r_ptr_rv <= 1'b0;
        end else begin
            r_reach  <= n_reach;
            r_pvalid <= n_pvalid;
            if (i_ptr_re) begin
                r_ptr_rv <= r_pvalid[i_ptr_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lvl_we) begin
            lvl_mem[i_lvl_waddr] <= i_lvl_wdata;
        end
        if (i_lvl_re) begin
            o_lvl_rdata <= lvl_mem[i_lvl_raddr];
        end
        if (i_ptr_we) begin
            ptr_mem[i_ptr_waddr] <= i_ptr_wdata;
        end
        if (i_ptr_re) begin
            r_ptr_rd <= ptr_mem[i_ptr_raddr];
        end
    end

    assign o_reach     = r_reach;
    assign o_ptr_rdata = r_ptr_rv ? r_ptr_rd : '0;

endmodule

@@ sv/max_flow_min_cut_engine.sv @@
// Top level: edge loading, Dinic sequencer, min-cut sweep and result output.
`timescale 1ns / 1ps
// Usage:
//  Slave channel carries one edge per item; tlast marks the final edge of a graph.
//  Each edge, up to MAX_EDGES, is written to the edge table as it is accepted.
//  After the final edge the block stops accepting items and runs the flow search:
//  each level build walks the whole arc table once per queued vertex, each path
//  probe reads the level of every arc tried, and each augmenting path updates the
//  flow of every arc on it. The run time is data dependent and bounded by the edge
//  table walks. Then two passes over the edges count and list cut edges.
//  Master channel gives one header item (flow, cut count, cut_edge 0), then one item
//  per cut edge in ascending order; tlast on the final one.
//  A stalled master channel holds the sequencer at the next result; the output
//  register is released as soon as it is taken.
//  The user must write the vertex count register through i_cfg_we / i_cfg_wdata
//  only while idle; the block does not enforce this.
//  Reset empties the edge table, clears all valid bits and sets vertex count to 2.
module max_flow_min_cut_engine
    import mfmc_pkg::*;
#(
    parameter int unsigned MAX_VERTS  = MAX_VERTS_DEF,
    parameter int unsigned MAX_EDGES  = MAX_EDGES_DEF,
    parameter int unsigned PUSH_LIMIT = PUSH_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // from_vertex[6:0], to_vertex[13:7], capacity[43:14]
    input  logic        i_s_tlast,   // last_edge
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // flow_total[34:0], cut_count[40:35], cut_edge[46:41]
    output logic        o_m_tlast    // last_result
);

    localparam int unsigned VW  = $clog2(MAX_VERTS);
    localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int unsigned ECW = $clog2(MAX_EDGES + 1);
    localparam int unsigned PW  = $clog2(2 * MAX_EDGES + 1);
    localparam int unsigned XW  = VW + 8;
    localparam int unsigned SDW = VW + CAP_W + PW;

    t_state              r_state, n_state;
    logic [ECW-1:0]      r_ec, n_ec;
    logic [VNUM_W-1:0]   r_vcount;
    logic                r_want, n_want;
    logic [FLOW_W-1:0]   r_acc, n_acc;
    logic [VW:0]         r_head, n_head, r_tail, n_tail;
    logic [VW-1:0]       r_bf, n_bf, r_lvl, n_lvl, r_cur, n_cur, r_depth, n_depth;
    logic [VW-1:0]       r_idx, n_idx;
    logic [PW-1:0]       r_ptr, n_ptr;
    logic [CAP_W-1:0]    r_cap, n_cap;
    logic [ECW-1:0]      r_k, n_k;
    logic [CNT_W-1:0]    r_cnt, n_cnt, r_r, n_r;
    logic                r_ovalid, n_ovalid;
    logic [FLOW_W-1:0]   r_oflow, n_oflow;
    logic [CNT_W-1:0]    r_ocnt, n_ocnt, r_oedge, n_oedge;
    logic                r_olast, n_olast;

    logic [XW-1:0]       vn;
    logic [VW-1:0]       sink;
    logic [PW-1:0]       arc_end;
    logic                slot_free;
    logic                is_cut;

    logic                tab_we, arc_re, arc_upd;
    logic [PW-1:0]       arc_raddr;
    logic [VW-1:0]       a_from, a_to;
    logic signed [31:0]  a_res;
    logic                a_live;

    logic                lvl_clr, lvl_we, lvl_re, ptr_clr, ptr_we, ptr_re;
    logic [VW-1:0]       lvl_waddr, lvl_wdata, lvl_raddr, lvl_rdata, ptr_waddr, ptr_raddr;
    logic [PW-1:0]       ptr_rdata;
    logic [MAX_VERTS-1:0] reach;

    logic [VW-1:0]       q_mem [MAX_VERTS];
    logic [VW-1:0]       q_rdata;
    logic                q_we, q_re;
    logic [VW-1:0]       q_waddr;
    logic [SDW-1:0]      s_mem [MAX_VERTS];
    logic [SDW-1:0]      s_rdata;
    logic                s_we, s_re;
    logic [VW-1:0]       s_waddr, s_raddr;
    logic [VW-1:0]       s_vert;
    logic [CAP_W-1:0]    s_cap;
    logic [PW-1:0]       s_arc;

    assign o_s_tready = (r_state == S_LOAD);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_oedge, r_ocnt, r_oflow};
    assign o_m_tlast  = r_olast;

    assign s_arc  = s_rdata[PW-1:0];
    assign s_cap  = s_rdata[PW+CAP_W-1:PW];
    assign s_vert = s_rdata[SDW-1:PW+CAP_W];

    always_comb begin
        if (r_vcount < 7'd2) begin
            vn = XW'(2);
        end else if (XW'(r_vcount) > XW'(MAX_VERTS)) begin
            vn = XW'(MAX_VERTS);
        end else begin
            vn = XW'(r_vcount);
        end
        sink      = VW'(vn - XW'(1));
        arc_end   = PW'({r_ec, 1'b0});
        slot_free = !r_ovalid || i_m_tready;
        is_cut    = a_live && (reach[a_from] != reach[a_to]);
    end

    mfmc_arc_table #(
        .MAX_VERTS(MAX_VERTS),
        .MAX_EDGES(MAX_EDGES)
    ) u_arcs (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (EAW'(r_ec)),
        .i_wfrom (VW'(vert_index(i_s_tdata[6:0], MAX_VERTS))),
        .i_wto   (VW'(vert_index(i_s_tdata[13:7], MAX_VERTS))),
        .i_wcap  (i_s_tdata[43:14]),
        .i_re    (arc_re),
        .i_raddr (arc_raddr),
        .i_upd   (arc_upd),
        .i_amt   (r_cap),
        .i_n     (vn),
        .o_from  (a_from),
        .o_to    (a_to),
        .o_res   (a_res),
        .o_live  (a_live)
    );

    mfmc_vertex_store #(
        .MAX_VERTS(MAX_VERTS),
        .MAX_EDGES(MAX_EDGES)
    ) u_verts (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lvl_clr   (lvl_clr),
        .i_lvl_we    (lvl_we),
        .i_lvl_waddr (lvl_waddr),
        .i_lvl_wdata (lvl_wdata),
        .i_lvl_re    (lvl_re),
        .i_lvl_raddr (lvl_raddr),
        .o_lvl_rdata (lvl_rdata),
        .o_reach     (reach),
        .i_ptr_clr   (ptr_clr),
        .i_ptr_we    (ptr_we),
        .i_ptr_waddr (ptr_waddr),
        .i_ptr_wdata (r_ptr),
        .i_ptr_re    (ptr_re),
        .i_ptr_raddr (ptr_raddr),
        .o_ptr_rdata (ptr_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            q_mem[q_waddr] <= (r_state == S_BFS_INIT) ? '0 : a_to;
        end
        if (q_re) begin
            q_rdata <= q_mem[r_head[VW-1:0]];
        end
        if (s_we) begin
            s_mem[s_waddr] <= {r_cur, r_cap, r_ptr};
        end
        if (s_re) begin
            s_rdata <= s_mem[s_raddr];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ec     = r_ec;
        n_want   = r_want;
        n_acc    = r_acc;
        n_head   = r_head;
        n_tail   = r_tail;
        n_bf     = r_bf;
        n_lvl    = r_lvl;
        n_cur    = r_cur;
        n_depth  = r_depth;
        n_idx    = r_idx;
        n_ptr    = r_ptr;
        n_cap    = r_cap;
        n_k      = r_k;
        n_cnt    = r_cnt;
        n_r      = r_r;
        n_ovalid = r_ovalid && !i_m_tready;
        n_oflow  = r_oflow;
        n_ocnt   = r_ocnt;
        n_oedge  = r_oedge;
        n_olast  = r_olast;
        tab_we    = 1'b0;
        arc_re    = 1'b0;
        arc_raddr = r_ptr;
        arc_upd   = 1'b0;
        lvl_clr   = 1'b0;
        lvl_we    = 1'b0;
        lvl_waddr = a_to;
        lvl_wdata = r_want ? (r_lvl + VW'(1)) : '0;
        lvl_re    = 1'b0;
        lvl_raddr = a_to;
        ptr_clr   = 1'b0;
        ptr_we    = 1'b0;
        ptr_waddr = r_cur;
        ptr_re    = 1'b0;
        ptr_raddr = a_to;
        q_we      = 1'b0;
        q_re      = 1'b0;
        q_waddr   = r_tail[VW-1:0];
        s_we      = 1'b0;
        s_waddr   = r_depth;
        s_re      = 1'b0;
        s_raddr   = r_depth - VW'(1);

        unique case (r_state)
            S_LOAD: begin
                if (i_s_tvalid) begin
                    if (ECW'(MAX_EDGES) > r_ec) begin
                        tab_we = 1'b1;
                        n_ec   = r_ec + ECW'(1);
                    end
                    if (i_s_tlast) begin
                        n_want  = 1'b1;
                        n_acc   = '0;
                        n_state = S_BFS_INIT;
                    end
                end
            end
            S_BFS_INIT: begin
                lvl_clr   = 1'b1;
                lvl_we    = 1'b1;
                lvl_waddr = '0;
                lvl_wdata = '0;
                q_we      = 1'b1;
                q_waddr   = '0;
                n_tail    = (VW+1)'(1);
                n_head    = '0;
                n_state   = S_BFS_POP;
            end
            S_BFS_POP: begin
                if (r_head < r_tail) begin
                    q_re    = 1'b1;
                    n_head  = r_head + (VW+1)'(1);
                    n_state = S_BFS_DEQ;
                end else begin
                    n_state = S_BFS_END;
                end
            end
            S_BFS_DEQ: begin
                n_bf      = q_rdata;
                lvl_re    = 1'b1;
                lvl_raddr = q_rdata;
                n_state   = S_BFS_LVL;
            end
            S_BFS_LVL: begin
                n_lvl   = lvl_rdata;
                n_ptr   = '0;
                n_state = S_BFS_ARC;
            end
            S_BFS_ARC: begin
                if (r_ptr < arc_end) begin
                    arc_re  = 1'b1;
                    n_state = S_BFS_EV;
                end else begin
                    n_state = S_BFS_POP;
                end
            end
            S_BFS_EV: begin
                if (a_live && a_from == r_bf && a_res > 32'sd0 && !reach[a_to]
                        && r_tail < (VW+1)'(MAX_VERTS)) begin
                    lvl_we = 1'b1;
                    q_we   = 1'b1;
                    n_tail = r_tail + (VW+1)'(1);
                end
                n_ptr   = r_ptr + PW'(1);
                n_state = S_BFS_ARC;
            end
            S_BFS_END: begin
                if (r_want) begin
                    if (reach[sink]) begin
                        n_state = S_AUG_INIT;
                    end else begin
                        n_want  = 1'b0;
                        n_state = S_BFS_INIT;
                    end
                end else begin
                    n_k     = '0;
                    n_cnt   = '0;
                    n_state = S_CNT_RD;
                end
            end
            S_AUG_INIT: begin
                ptr_clr = 1'b1;
                n_cur   = '0;
                n_cap   = CAP_W'(PUSH_LIMIT);
                n_depth = '0;
                n_ptr   = '0;
                n_state = S_AUG_TOP;
            end
            S_AUG_TOP: begin
                if (r_cap != '0 && r_cur == sink) begin
                    n_idx   = '0;
                    n_state = S_APPLY_RS;
                end else if (r_cap != '0 && r_ptr < arc_end) begin
                    arc_re  = 1'b1;
                    n_state = S_SCAN_EV;
                end else if (r_depth == '0) begin
                    n_state = S_BFS_INIT;
                end else begin
                    ptr_we  = 1'b1;
                    s_re    = 1'b1;
                    n_state = S_POP;
                end
            end
            S_SCAN_EV: begin
                lvl_re  = 1'b1;
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (a_live && a_from == r_cur && reach[a_to]
                        && (VW+1)'(lvl_rdata) == (VW+1)'(r_depth) + (VW+1)'(1)
                        && (VW+1)'(r_depth) + (VW+1)'(1) < (VW+1)'(MAX_VERTS)) begin
                    s_we    = 1'b1;
                    ptr_we  = 1'b1;
                    ptr_re  = 1'b1;
                    if (a_res < $signed({2'b00, r_cap})) begin
                        n_cap = a_res[CAP_W-1:0];
                    end
                    n_cur   = a_to;
                    n_depth = r_depth + VW'(1);
                    n_state = S_ENTER;
                end else begin
                    n_ptr   = r_ptr + PW'(1);
                    n_state = S_AUG_TOP;
                end
            end
            S_ENTER: begin
                n_ptr   = ptr_rdata;
                n_state = S_AUG_TOP;
            end
            S_POP: begin
                n_cur   = s_vert;
                n_cap   = s_cap;
                n_ptr   = s_arc + PW'(1);
                n_depth = r_depth - VW'(1);
                n_state = S_AUG_TOP;
            end
            S_APPLY_RS: begin
                if (r_idx < r_depth) begin
                    s_re    = 1'b1;
                    s_raddr = r_idx;
                    n_state = S_APPLY_RF;
                end else begin
                    n_state = S_APPLY_END;
                end
            end
            S_APPLY_RF: begin
                arc_re    = 1'b1;
                arc_raddr = s_arc;
                n_state   = S_APPLY_WR;
            end
            S_APPLY_WR: begin
                arc_upd = 1'b1;
                n_idx   = r_idx + VW'(1);
                n_state = S_APPLY_RS;
            end
            S_APPLY_END: begin
                n_acc   = r_acc + FLOW_W'(r_cap);
                n_state = S_AUG_INIT;
            end
            S_CNT_RD: begin
                if (r_k < r_ec) begin
                    arc_re    = 1'b1;
                    arc_raddr = PW'({r_k, 1'b0});
                    n_state   = S_CNT_EV;
                end else begin
                    n_state = S_HDR;
                end
            end
            S_CNT_EV: begin
                if (is_cut) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
                n_k     = r_k + ECW'(1);
                n_state = S_CNT_RD;
            end
            S_HDR: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_oflow  = r_acc;
                    n_ocnt   = r_cnt;
                    n_oedge  = '0;
                    n_olast  = (r_cnt == '0);
                    n_k      = '0;
                    n_r      = CNT_W'(1);
                    n_state  = S_EM_RD;
                end
            end
            S_EM_RD: begin
                if (r_k < r_ec) begin
                    arc_re    = 1'b1;
                    arc_raddr = PW'({r_k, 1'b0});
                    n_state   = S_EM_EV;
                end else begin
                    n_ec    = '0;
                    n_state = S_LOAD;
                end
            end
            S_EM_EV: begin
                if (!is_cut) begin
                    n_k     = r_k + ECW'(1);
                    n_state = S_EM_RD;
                end else if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_oflow  = r_acc;
                    n_ocnt   = r_cnt;
                    n_oedge  = CNT_W'(r_k + ECW'(1));
                    n_olast  = (r_r == r_cnt);
                    n_r      = r_r + CNT_W'(1);
                    n_k      = r_k + ECW'(1);
                    n_state  = S_EM_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_ec     <= '0;
            r_vcount <= VCOUNT_RST;
            r_want   <= 1'b0;
            r_acc    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ec     <= n_ec;
            r_want   <= n_want;
            r_acc    <= n_acc;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head  <= n_head;
        r_tail  <= n_tail;
        r_bf    <= n_bf;
        r_lvl   <= n_lvl;
        r_cur   <= n_cur;
        r_depth <= n_depth;
        r_idx   <= n_idx;
        r_ptr   <= n_ptr;
        r_cap   <= n_cap;
        r_k     <= n_k;
        r_cnt   <= n_cnt;
        r_r     <= n_r;
        r_oflow <= n_oflow;
        r_ocnt  <= n_ocnt;
        r_oedge <= n_oedge;
        r_olast <= n_olast;
    end

    a_path_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AUG_TOP) |-> reach[r_cur])
        else $error("path vertex outside level graph");

    a_res_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CHK) |-> !a_res[31])
        else $error("arc flow exceeds capacity");

    a_apply_at_sink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY_RS && r_idx == '0) |-> (r_cur == sink && r_cap != '0))
        else $error("augment without reaching sink");

endmodule
